// ===== design/msb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msb_pkg;

	localparam int NUM_STACKS = 8;
	localparam int CAPACITY   = 64;
	localparam int STACK_W    = $clog2(NUM_STACKS);
	localparam int SLOT_W     = $clog2(CAPACITY);
	localparam int PTR_W      = $clog2(CAPACITY + 1);
	localparam int DATA_W     = 32;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [PTR_W-1:0]  wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} link_req_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} value_req_t;

endpackage

`default_nettype wire

// ===== design/msb_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface msb_in_if import msb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [STACK_W-1:0]         stack_index;
	logic signed [DATA_W-1:0]   push_value;

	modport source (output valid, output operation, output stack_index, output push_value,
		input ready);
	modport sink (input valid, input operation, input stack_index, input push_value,
		output ready);
endinterface

`default_nettype wire

// ===== design/msb_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface msb_out_if import msb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic signed [DATA_W-1:0]   pop_value;

	modport source (output valid, output status, output pop_value, input ready);
	modport sink (input valid, input status, input pop_value, output ready);
endinterface

`default_nettype wire

// ===== design/msb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msb_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/msb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msb_ctrl import msb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	msb_in_if.sink                 in,
	msb_out_if.source              out,
	input  wire logic [PTR_W-1:0]  link_rd,
	input  wire logic [DATA_W-1:0] value_rd,
	output link_req_t              link_req,
	output value_req_t             value_req
);

	state_t state_q, state_d;

	logic [PTR_W-1:0]    heads_q [NUM_STACKS];
	logic [PTR_W-1:0]    free_head_q;
	logic [CAPACITY-1:0] link_valid_q;

	logic                op_s1;
	logic [STACK_W-1:0]  sel_s1;
	logic [DATA_W-1:0]   val_s1;
	logic [PTR_W-1:0]    slot_s1;
	logic                lvalid_s1;

	logic                out_valid_q;
	status_t             status_q;
	logic [DATA_W-1:0]   pop_value_q;

	logic                in_ready;
	logic                exec_fire;
	logic                accept;
	logic [PTR_W-1:0]    slot_a;
	logic                slot_ok;
	logic [PTR_W-1:0]    next_link;
	logic                is_pop;

	// state machine: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || out.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state machine: outputs
	always_comb begin
		in_ready  = 1'b0;
		exec_fire = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EXEC: exec_fire = !out_valid_q || out.ready;
			default: begin
				in_ready  = 1'b0;
				exec_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign accept    = in.valid && in_ready;
	assign slot_a    = (op_t'(in.operation) == OP_POP) ? heads_q[in.stack_index] : free_head_q;
	assign is_pop    = (op_t'(op_s1) == OP_POP);
	assign slot_ok   = (slot_s1 < PTR_W'(CAPACITY));
	// unwritten links read as their reset chain value (slot + 1) instead of the link memory
	assign next_link = lvalid_s1 ? link_rd : PTR_W'(slot_s1 + PTR_W'(1));

	always_comb begin
		link_req.re    = accept;
		link_req.raddr = slot_a[SLOT_W-1:0];
		link_req.we    = exec_fire && slot_ok;
		link_req.waddr = slot_s1[SLOT_W-1:0];
		link_req.wdata = is_pop ? free_head_q : heads_q[sel_s1];

		value_req.re    = accept;
		value_req.raddr = slot_a[SLOT_W-1:0];
		value_req.we    = exec_fire && slot_ok && !is_pop;
		value_req.waddr = slot_s1[SLOT_W-1:0];
		value_req.wdata = val_s1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= in.operation;
			sel_s1    <= in.stack_index;
			val_s1    <= in.push_value;
			slot_s1   <= slot_a;
			lvalid_s1 <= link_valid_q[slot_a[SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				heads_q[i] <= PTR_W'(CAPACITY);
			end
			free_head_q  <= '0;
			link_valid_q <= '0;
		end else if (exec_fire && slot_ok) begin
			link_valid_q[slot_s1[SLOT_W-1:0]] <= 1'b1;
			if (is_pop) begin
				heads_q[sel_s1] <= next_link;
				free_head_q     <= slot_s1;
			end else begin
				heads_q[sel_s1] <= slot_s1;
				free_head_q     <= next_link;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			if (!slot_ok) begin
				status_q    <= is_pop ? STAT_EMPTY : STAT_FULL;
				pop_value_q <= '0;
			end else begin
				status_q    <= STAT_DONE;
				pop_value_q <= is_pop ? value_rd : '0;
			end
		end
	end

	assign in.ready      = in_ready;
	assign out.valid     = out_valid_q;
	assign out.status    = status_q;
	assign out.pop_value = pop_value_q;

endmodule

`default_nettype wire

// ===== design/multi_stack_shared_buffer.sv =====
// an accepted request is read from the link and value memories and captured in the _s1 registers,
// then its result is registered in execute, which waits while an earlier result is not taken;
// one request is in flight at a time: the link memory read, then the pointer update and write-back
// reset: asynchronous, all stacks empty, free list chains every slot in order from slot 0
// link entries read their chained reset value until first written, so no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_shared_buffer import msb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	msb_in_if.sink    in,
	msb_out_if.source out
);

	link_req_t         link_req;
	value_req_t        value_req;
	logic [PTR_W-1:0]  link_rd;
	logic [DATA_W-1:0] value_rd;

	msb_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(PTR_W)
	) u_link_ram (
		.clk   (clk),
		.we    (link_req.we),
		.waddr (link_req.waddr),
		.wdata (link_req.wdata),
		.re    (link_req.re),
		.raddr (link_req.raddr),
		.rdata (link_rd)
	);

	msb_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_W)
	) u_value_ram (
		.clk   (clk),
		.we    (value_req.we),
		.waddr (value_req.waddr),
		.wdata (value_req.wdata),
		.re    (value_req.re),
		.raddr (value_req.raddr),
		.rdata (value_rd)
	);

	msb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.out       (out),
		.link_rd   (link_rd),
		.value_rd  (value_rd),
		.link_req  (link_req),
		.value_req (value_req)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready |=> !in.ready)
		else $error("request accepted while another is in progress");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && (out.status == STAT_FULL || out.status == STAT_EMPTY) |->
		out.pop_value == '0)
		else $error("refused request carries nonzero value");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> out.status != 2'd3)
		else $error("illegal status code");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready |-> !link_req.we && !value_req.we)
		else $error("memory write outside of execute");

endmodule

`default_nettype wire
